FILE: rtl/clrs_pkg.sv
// ----------------------------------------------------------------------------
// clrs_pkg
// Shared types, codes and constant tables of the character LCD refresh
// sequencer: command codes, queue entry layout, glyph ROM and init sequence.
// ----------------------------------------------------------------------------
package clrs_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_INIT  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic REG_UPPER_EN = 1'b0;
	localparam logic REG_LOWER_EN = 1'b1;

	localparam logic [7:0]  SPACE_CODE  = 8'h20;
	localparam logic [7:0]  DISP_ON_CMD = 8'h0C;
	localparam logic [7:0]  UPPER_ADDR  = 8'h80;
	localparam logic [7:0]  LOWER_ADDR  = 8'hC0;
	localparam logic [3:0]  INIT_LAST   = 4'd8;

	typedef logic [8:0] glyph_t;

	// One entry of the queue between front and back.
	typedef struct packed {
		logic       init;
		logic [7:0] byte_val;
		logic       data;
	} job_t;

	// Bit 8 is the font page, bits 7..0 the glyph. Entries 0..63 cover
	// 0xC0..0xFF, entry 64 is for 0xA8 and entry 65 for 0xB8.
	localparam glyph_t GLYPH_ROM [0:65] = '{
		9'h041, 9'h1BD, 9'h042, 9'h17C, 9'h17D, 9'h045, 9'h1C0, 9'h1C1,
		9'h1C2, 9'h1C3, 9'h1C4, 9'h1C5, 9'h182, 9'h048, 9'h04F, 9'h186,
		9'h050, 9'h043, 9'h188, 9'h1C7, 9'h1C8, 9'h058, 9'h1C9, 9'h1CA,
		9'h1CB, 9'h1CC, 9'h1CD, 9'h1CE, 9'h1CF, 9'h1D0, 9'h1D1, 9'h1D2,
		9'h061, 9'h1D3, 9'h1D4, 9'h1D5, 9'h1D6, 9'h065, 9'h1D7, 9'h1D8,
		9'h1D9, 9'h1DA, 9'h1DB, 9'h1DC, 9'h1DD, 9'h1DE, 9'h06F, 9'h1DF,
		9'h070, 9'h063, 9'h1E0, 9'h079, 9'h1E1, 9'h078, 9'h1E2, 9'h1E3,
		9'h1E4, 9'h1E5, 9'h1E6, 9'h1E7, 9'h1E8, 9'h1E9, 9'h1EA, 9'h1EB,
		9'h045, 9'h11F
	};

	function automatic glyph_t map_glyph(input logic [7:0] c);
		glyph_t g;
		if (c == 8'hA8) begin
			g = GLYPH_ROM[64];
		end else if (c == 8'hB8) begin
			g = GLYPH_ROM[65];
		end else if (c >= 8'hC0) begin
			g = GLYPH_ROM[c[5:0]];
		end else begin
			g = {1'b0, c};
		end
		return g;
	endfunction

	function automatic logic [7:0] init_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0, 4'd1, 4'd2: b = 8'h30;
			4'd3:             b = 8'h38;
			4'd4:             b = 8'h08;
			4'd5:             b = 8'h01;
			4'd6:             b = 8'h06;
			4'd7:             b = 8'h14;
			4'd8:             b = 8'h0C;
			default:          b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [10:0] init_wait(input logic [3:0] idx);
		logic [10:0] w;
		unique case (idx)
			4'd2:    w = 11'd0;
			4'd5:    w = 11'd1520;
			4'd0, 4'd1, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8: w = 11'd40;
			default: w = 11'd0;
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/clrs_ram.sv
// ----------------------------------------------------------------------------
// clrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module clrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/clrs_fifo.sv
// ----------------------------------------------------------------------------
// clrs_fifo
// Two-entry queue of frame jobs between the front and the back.
// ----------------------------------------------------------------------------
module clrs_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  clrs_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output clrs_pkg::job_t pop_job
);

	import clrs_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/clrs_front.sv
// ----------------------------------------------------------------------------
// clrs_front
// Accepts commands, keeps the text store, line enables and the refresh
// phase, and turns each refresh tick or init command into a queued job.
// ----------------------------------------------------------------------------
module clrs_front #(
	parameter int LINE_LENGTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     command,
	input  logic [4:0]     position,
	input  logic [7:0]     char_code,
	input  logic           cfg_valid,
	input  logic           cfg_index,
	input  logic           cfg_data,
	output logic           job_valid,
	input  logic           job_ready,
	output clrs_pkg::job_t job
);

	import clrs_pkg::*;

	localparam int CELLS = 2 * LINE_LENGTH;
	localparam int CW    = $clog2(CELLS);
	localparam logic [6:0]    CELLS_W   = 7'(CELLS);
	localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);
	localparam logic [CW-1:0] LINE_W    = CW'(LINE_LENGTH);

	typedef enum logic [2:0] {
		PH_PAGE  = 3'b001,
		PH_ADDR  = 3'b010,
		PH_GLYPH = 3'b100
	} phase_t;

	phase_t         phase_q;
	logic [CW-1:0]  cursor_q;
	logic [CW-1:0]  cursor_d;
	logic [7:0]     pending_q;
	logic           upper_en_q;
	logic           lower_en_q;
	logic [CELLS-1:0] valid_q;
	logic           hit_q;
	logic [7:0]     hit_data_q;
	logic [7:0]     rd_data;
	logic           accept;
	logic           is_tick;
	logic           wr_en;
	logic [6:0]     pos_w;
	logic [CW-1:0]  waddr;
	logic           upper;
	logic [7:0]     stored;
	logic [7:0]     shown;
	glyph_t         glyph;
	logic [7:0]     column;

	assign in_ready = job_ready;
	assign accept   = in_valid && in_ready;
	assign is_tick  = accept && (cmd_t'(command) == CMD_TICK);
	assign pos_w    = {2'b00, position};
	assign waddr    = pos_w[CW-1:0];
	assign wr_en    = accept && (cmd_t'(command) == CMD_WRITE) && (pos_w < CELLS_W);

	always_comb begin
		cursor_d = cursor_q;
		if (is_tick && phase_q == PH_GLYPH) begin
			cursor_d = (cursor_q == LAST_CELL) ? '0 : cursor_q + CW'(1);
		end
	end

	clrs_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(char_code),
		.raddr(cursor_d),
		.rdata(rd_data)
	);

	// The store read is registered, so a write that landed on the cell being
	// read in the same cycle is forwarded. Cells never written read as spaces.
	always_comb begin
		if (hit_q) begin
			stored = hit_data_q;
		end else if (valid_q[cursor_q]) begin
			stored = rd_data;
		end else begin
			stored = SPACE_CODE;
		end
	end

	assign upper  = (cursor_q < LINE_W);
	assign shown  = (upper ? upper_en_q : lower_en_q) ? stored : SPACE_CODE;
	assign glyph  = map_glyph(shown);
	assign column = 8'(upper ? cursor_q : cursor_q - LINE_W);

	always_comb begin
		job_valid     = accept && (is_tick || cmd_t'(command) == CMD_INIT);
		job.init      = (cmd_t'(command) == CMD_INIT);
		job.byte_val  = DISP_ON_CMD | {7'd0, glyph[8]};
		job.data      = 1'b0;
		unique case (phase_q)
			PH_ADDR: begin
				job.byte_val = (upper ? UPPER_ADDR : LOWER_ADDR) | column;
			end
			PH_GLYPH: begin
				job.byte_val = pending_q;
				job.data     = 1'b1;
			end
			default: begin
				job.byte_val = DISP_ON_CMD | {7'd0, glyph[8]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		hit_data_q <= char_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_PAGE;
			cursor_q   <= '0;
			pending_q  <= 8'd0;
			upper_en_q <= 1'b1;
			lower_en_q <= 1'b1;
			valid_q    <= '0;
			hit_q      <= 1'b0;
		end else begin
			cursor_q <= cursor_d;
			hit_q    <= wr_en && (waddr == cursor_d);
			if (wr_en) begin
				valid_q[waddr] <= 1'b1;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_UPPER_EN: upper_en_q <= cfg_data;
					REG_LOWER_EN: lower_en_q <= cfg_data;
				endcase
			end
			if (is_tick) begin
				unique case (phase_q)
					PH_ADDR:  phase_q <= PH_GLYPH;
					PH_GLYPH: phase_q <= PH_PAGE;
					default: begin
						phase_q   <= PH_ADDR;
						pending_q <= glyph[7:0];
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/clrs_back.sv
// ----------------------------------------------------------------------------
// clrs_back
// Takes jobs from the queue and drives the frame output register, expanding
// an init job into the nine-frame setup sequence.
// ----------------------------------------------------------------------------
module clrs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  clrs_pkg::job_t job,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     spi_byte,
	output logic           is_data,
	output logic [10:0]    wait_us,
	output logic           last
);

	import clrs_pkg::*;

	typedef enum logic [1:0] {
		BK_PASS = 2'b01,
		BK_INIT = 2'b10
	} back_t;

	back_t      state_q;
	logic [3:0] idx_q;
	logic       load;

	assign load      = !out_valid || out_ready;
	assign job_ready = load && (state_q == BK_PASS);

	always_ff @(posedge clk) begin
		if (load) begin
			if (state_q == BK_INIT) begin
				spi_byte <= init_byte(idx_q);
				is_data  <= 1'b0;
				wait_us  <= init_wait(idx_q);
				last     <= (idx_q == INIT_LAST);
			end else if (job.init) begin
				spi_byte <= init_byte(4'd0);
				is_data  <= 1'b0;
				wait_us  <= init_wait(4'd0);
				last     <= 1'b0;
			end else begin
				spi_byte <= job.byte_val;
				is_data  <= job.data;
				wait_us  <= 11'd0;
				last     <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_PASS;
			idx_q     <= 4'd0;
			out_valid <= 1'b0;
		end else if (load) begin
			unique case (state_q)
				BK_INIT: begin
					out_valid <= 1'b1;
					idx_q     <= idx_q + 4'd1;
					if (idx_q == INIT_LAST) begin
						state_q <= BK_PASS;
					end
				end
				default: begin
					out_valid <= job_valid;
					if (job_valid && job.init) begin
						state_q <= BK_INIT;
						idx_q   <= 4'd1;
					end
				end
			endcase
		end
	end

endmodule

FILE: rtl/char_lcd_refresh_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_refresh_sequencer
// Refresh engine for a two-line character LCD on an SPI link.
// ----------------------------------------------------------------------------
// The block accepts one command beat per cycle while the two-entry job queue
// has room. A write stores a character and produces no frame; a refresh tick
// produces one frame; an init command produces nine frames. Frames leave one
// per cycle through the output register while the receiver is ready, so a
// run of ticks sustains one beat per cycle in and out. An init command keeps
// the back busy until its nine frames have left, so the input stalls once
// the job queue has filled. A tick's frame is registered in a queue slot and
// then in the output register. The text store is a RAM with one valid bit
// per cell, so no clearing pass follows reset and the block is ready at once.
module char_lcd_refresh_sequencer #(
	parameter int LINE_LENGTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [4:0]  position,
	input  logic [7:0]  char_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  spi_byte,
	output logic        is_data,
	output logic [10:0] wait_us,
	output logic        last
);

	import clrs_pkg::*;

	job_t push_job;
	job_t pop_job;
	logic push_valid;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;

	assign cfg_ready = 1'b1;

	clrs_front #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.position (position),
		.char_code(char_code),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.job_valid(push_valid),
		.job_ready(push_ready),
		.job      (push_job)
	);

	clrs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job)
	);

	clrs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(pop_valid),
		.job_ready(pop_ready),
		.job      (pop_job),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.spi_byte (spi_byte),
		.is_data  (is_data),
		.wait_us  (wait_us),
		.last     (last)
	);

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD refresh sequencer testbench
// Drives write, refresh tick, init and unused commands through the valid/ready
// input, predicts every SPI frame with an independent model of the text store,
// glyph mapping and three-phase refresh cycle, and checks each output beat in
// order. Runs several line-enable settings under varied idling and back-pressure.
// ----------------------------------------------------------------------------
module tb;
	import clrs_pkg::*;

	localparam int         LINE_CELLS = 16;
	localparam int         ALL_CELLS  = 2 * LINE_CELLS;
	localparam logic [7:0] BLANK      = 8'h20;
	localparam logic [7:0] PANEL_ON_CMD = 8'h0C;
	localparam logic [7:0] LINE1_BASE = 8'h80;
	localparam logic [7:0] LINE2_BASE = 8'hC0;

	localparam logic [8:0] CYR_FONT [0:65] = '{
		9'h041, 9'h1BD, 9'h042, 9'h17C, 9'h17D, 9'h045, 9'h1C0, 9'h1C1,
		9'h1C2, 9'h1C3, 9'h1C4, 9'h1C5, 9'h182, 9'h048, 9'h04F, 9'h186,
		9'h050, 9'h043, 9'h188, 9'h1C7, 9'h1C8, 9'h058, 9'h1C9, 9'h1CA,
		9'h1CB, 9'h1CC, 9'h1CD, 9'h1CE, 9'h1CF, 9'h1D0, 9'h1D1, 9'h1D2,
		9'h061, 9'h1D3, 9'h1D4, 9'h1D5, 9'h1D6, 9'h065, 9'h1D7, 9'h1D8,
		9'h1D9, 9'h1DA, 9'h1DB, 9'h1DC, 9'h1DD, 9'h1DE, 9'h06F, 9'h1DF,
		9'h070, 9'h063, 9'h1E0, 9'h079, 9'h1E1, 9'h078, 9'h1E2, 9'h1E3,
		9'h1E4, 9'h1E5, 9'h1E6, 9'h1E7, 9'h1E8, 9'h1E9, 9'h1EA, 9'h1EB,
		9'h045, 9'h11F
	};
	localparam logic [7:0]  SETUP_BYTES [0:8] = '{
		8'h30, 8'h30, 8'h30, 8'h38, 8'h08, 8'h01, 8'h06, 8'h14, 8'h0C
	};
	localparam logic [10:0] SETUP_WAITS [0:8] = '{
		11'd40, 11'd40, 11'd0, 11'd40, 11'd40, 11'd1520, 11'd40, 11'd40, 11'd40
	};

	typedef enum logic [1:0] {
		PH_PAGE  = 2'd0,
		PH_ADDR  = 2'd1,
		PH_GLYPH = 2'd2
	} lcd_phase_t;

	typedef struct {
		cmd_t       cmd;
		logic [4:0] pos;
		logic [7:0] code;
	} lcd_cmd_t;

	typedef struct {
		logic [7:0]  spi_byte;
		logic        is_data;
		logic [10:0] wait_us;
		logic        last;
	} spi_frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = 2'd0;
	logic [4:0]  position = 5'd0;
	logic [7:0]  char_code = 8'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  spi_byte;
	logic        is_data;
	logic [10:0] wait_us;
	logic        last;

	lcd_cmd_t   pending_cmds [$];
	spi_frame_t frames_due [$];
	lcd_cmd_t   next_cmd;
	spi_frame_t oldest_frame;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	logic hold_go = 1'b0;
	int mismatches = 0;

	logic       upper_on;
	logic       lower_on;
	lcd_phase_t phase_shadow;
	logic [4:0] cursor_shadow;
	logic [7:0] glyph_shadow;
	logic [7:0] text_shadow [ALL_CELLS];

	char_lcd_refresh_sequencer #(.LINE_LENGTH(LINE_CELLS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.position(position),
		.char_code(char_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.spi_byte(spi_byte),
		.is_data(is_data),
		.wait_us(wait_us),
		.last(last)
	);

	always #5 clk = ~clk;

	function automatic logic [8:0] font_of(input logic [7:0] c);
		if (c == 8'hA8) return CYR_FONT[64];
		if (c == 8'hB8) return CYR_FONT[65];
		if (c >= 8'hC0) return CYR_FONT[c - 8'hC0];
		return {1'b0, c};
	endfunction

	task automatic predict_frames(input cmd_t cmd, input logic [4:0] pos,
			input logic [7:0] code);
		spi_frame_t f;
		logic [8:0] g;
		logic [7:0] shown;
		f.is_data = 1'b0;
		f.wait_us = 11'd0;
		f.last = 1'b1;
		case (cmd)
			CMD_WRITE: begin
				text_shadow[pos] = code;
			end
			CMD_INIT: begin
				for (int i = 0; i < 9; i++) begin
					f.spi_byte = SETUP_BYTES[i];
					f.wait_us = SETUP_WAITS[i];
					f.last = (i == 8);
					frames_due.push_back(f);
				end
			end
			CMD_TICK: begin
				case (phase_shadow)
					PH_ADDR: begin
						if (cursor_shadow < LINE_CELLS)
							f.spi_byte = LINE1_BASE | 8'(cursor_shadow);
						else
							f.spi_byte = LINE2_BASE | 8'(cursor_shadow - LINE_CELLS);
						phase_shadow = PH_GLYPH;
					end
					PH_GLYPH: begin
						f.spi_byte = glyph_shadow;
						f.is_data = 1'b1;
						cursor_shadow = (cursor_shadow == ALL_CELLS - 1) ? 5'd0 : cursor_shadow + 5'd1;
						phase_shadow = PH_PAGE;
					end
					default: begin
						if ((cursor_shadow < LINE_CELLS) ? upper_on : lower_on)
							shown = text_shadow[cursor_shadow];
						else
							shown = BLANK;
						g = font_of(shown);
						f.spi_byte = PANEL_ON_CMD | {7'd0, g[8]};
						glyph_shadow = g[7:0];
						phase_shadow = PH_ADDR;
					end
				endcase
				frames_due.push_back(f);
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string field, input logic [10:0] want,
			input logic [10:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endtask

	// Command driver.
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_cmd = pending_cmds.pop_front();
				in_valid <= 1'b1;
				command <= next_cmd.cmd;
				position <= next_cmd.pos;
				char_code <= next_cmd.code;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here in cycles.
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= 300;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	// Frame checker, predictor and register shadow.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_on = 1'b1;
			lower_on = 1'b1;
			phase_shadow = PH_PAGE;
			cursor_shadow = 5'd0;
			glyph_shadow = 8'd0;
			for (int i = 0; i < ALL_CELLS; i++)
				text_shadow[i] = BLANK;
		end else begin
			if (out_valid && out_ready) begin
				if (frames_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected frame, expected none, actual %h", $time, spi_byte);
				end else begin
					oldest_frame = frames_due.pop_front();
					compare_field("spi_byte", 11'(oldest_frame.spi_byte), 11'(spi_byte));
					compare_field("is_data", 11'(oldest_frame.is_data), 11'(is_data));
					compare_field("wait_us", oldest_frame.wait_us, wait_us);
					compare_field("last", 11'(oldest_frame.last), 11'(last));
				end
			end
			if (in_valid && in_ready)
				predict_frames(cmd_t'(command), position, char_code);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_UPPER_EN)
					upper_on = cfg_data;
				else
					lower_on = cfg_data;
			end
		end
	end

	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(9);
		if (r < 5) return 8'($urandom_range(8'hFF, 8'hC0));
		if (r == 5) return 8'hA8;
		if (r == 6) return 8'hB8;
		return 8'($urandom);
	endfunction

	task automatic queue_cmd(input cmd_t cmd, input logic [4:0] pos, input logic [7:0] code);
		lcd_cmd_t c;
		c.cmd = cmd;
		c.pos = pos;
		c.code = code;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_random(input int n);
		int r;
		cmd_t cmd;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 50) cmd = CMD_TICK;
			else if (r < 85) cmd = CMD_WRITE;
			else if (r < 93) cmd = CMD_INIT;
			else cmd = CMD_NONE;
			queue_cmd(cmd, 5'($urandom), pick_code());
		end
	endtask

	// Wait until the sender is empty and every frame has come, then let any
	// write still in the pipeline settle.
	task automatic drain();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || in_valid || frames_due.size() != 0);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic up, input logic lo, input int send_pct,
			input int recv_pct, input int n);
		write_reg(REG_UPPER_EN, up);
		write_reg(REG_LOWER_EN, lo);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		queue_random(n / 2);
		drain();
		queue_random(n - n / 2);
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_cmd(CMD_INIT, 5'd0, 8'h00);
		queue_cmd(CMD_WRITE, 5'd0, 8'hA8);
		queue_cmd(CMD_WRITE, 5'd1, 8'hB8);
		queue_cmd(CMD_WRITE, 5'd31, 8'hFF);
		queue_cmd(CMD_WRITE, 5'd16, 8'hC0);
		queue_cmd(CMD_NONE, 5'd31, 8'hFF);
		repeat (4) queue_cmd(CMD_TICK, 5'd0, 8'h00);
		// An init between the phases of one cell must not disturb the cycle.
		queue_cmd(CMD_INIT, 5'd31, 8'hFF);
		repeat (2) queue_cmd(CMD_TICK, 5'd31, 8'hFF);
		queue_cmd(CMD_WRITE, 5'd2, 8'h00);
		queue_cmd(CMD_WRITE, 5'd3, 8'h7F);
		repeat (6) queue_cmd(CMD_TICK, 5'd0, 8'h00);
		drain();

		run_phase(1'b1, 1'b1, 0, 0, 60);
		run_phase(1'b0, 1'b1, 76, 0, 60);
		run_phase(1'b1, 1'b0, 0, 76, 60);
		run_phase(1'b0, 1'b0, 6, 6, 60);

		// The receiver holds off while ticks keep arriving, so the block fills.
		write_reg(REG_UPPER_EN, 1'b1);
		write_reg(REG_LOWER_EN, 1'b1);
		@(negedge clk);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		repeat (40) queue_cmd(CMD_TICK, 5'($urandom), 8'($urandom));
		queue_cmd(CMD_INIT, 5'd0, 8'h00);
		queue_random(40);
		drain();

		if (mismatches == 0 && frames_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
